### hw/rtl/awstat_pkg.sv
package awstat_pkg;

  // Angle format: one turn in whole counts, plus fractional bits
  localparam int unsigned COUNTS_PER_TURN = 16384;
  localparam int unsigned FRACTION_BITS   = 8;
  localparam int unsigned RAW_W           = $clog2(COUNTS_PER_TURN);
  localparam int unsigned ANGLE_W         = RAW_W + FRACTION_BITS;
  localparam int unsigned ROUND_HALF      = 1 << (FRACTION_BITS - 1);

  // Deviation spans plus or minus half a turn in whole counts
  localparam int unsigned DEV_W    = RAW_W + 1;
  localparam int unsigned SPREAD_W = 15;

  // Residual and accumulators
  localparam int unsigned RES_W = 14;
  localparam int unsigned SQ_W  = 2 * RES_W - 1;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned SUM_W = 64;

  typedef enum logic [1:0] {
    ACT_SAMPLE   = 2'd0,
    ACT_MISS     = 2'd1,
    ACT_SNAPSHOT = 2'd2
  } action_e;

endpackage

### hw/rtl/angle_window_statistics.sv
// Window statistics over encoder samples. Each input transaction carries one action: a good
// sample, a missed read, or a snapshot. A snapshot produces one output transaction with the
// window's counts, raw and filtered peak-to-peak spreads and the sum of squared residuals,
// then clears the window; the other actions produce no output. Counters and the sum saturate.
// Throughput is one transaction per cycle unless a snapshot meets a full output register.
// Inputs and the residual square are registered ahead of the window state update.
module angle_window_statistics (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            action_i,
  input  logic [awstat_pkg::RAW_W-1:0]          raw_angle_i,
  input  logic [awstat_pkg::ANGLE_W-1:0]        filtered_angle_i,
  input  logic signed [awstat_pkg::RES_W-1:0]   residual_i,
  input  logic                                  was_gated_i,
  input  logic                                  is_locked_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [awstat_pkg::CNT_W-1:0]          sample_count_o,
  output logic [awstat_pkg::CNT_W-1:0]          miss_count_o,
  output logic [awstat_pkg::CNT_W-1:0]          gated_count_o,
  output logic [awstat_pkg::SPREAD_W-1:0]       raw_spread_o,
  output logic [awstat_pkg::SPREAD_W-1:0]       filtered_spread_o,
  output logic [awstat_pkg::SUM_W-1:0]          residual_square_sum_o
);

  localparam int unsigned CNT_W = awstat_pkg::CNT_W;
  localparam int unsigned SUM_W = awstat_pkg::SUM_W;
  localparam int unsigned DEV_W = awstat_pkg::DEV_W;

  // Input stage
  logic                              s1_valid_q;
  logic [1:0]                        s1_action_q;
  logic [awstat_pkg::RAW_W-1:0]      s1_raw_q;
  logic [awstat_pkg::ANGLE_W-1:0]    s1_filt_q;
  logic                              s1_gated_q;
  logic                              s1_locked_q;
  logic [awstat_pkg::SQ_W-1:0]       s1_sq_q;
  logic signed [2*awstat_pkg::RES_W-1:0] res_prod;

  // Window state
  logic                              ref_valid_q, ref_valid_d;
  logic [awstat_pkg::ANGLE_W-1:0]    ref_q, ref_d;
  logic signed [DEV_W-1:0]           raw_low_q, raw_low_d;
  logic signed [DEV_W-1:0]           raw_high_q, raw_high_d;
  logic signed [DEV_W-1:0]           filt_low_q, filt_low_d;
  logic signed [DEV_W-1:0]           filt_high_q, filt_high_d;
  logic [CNT_W-1:0]                  acc_q, acc_d;
  logic [CNT_W-1:0]                  miss_q, miss_d;
  logic [CNT_W-1:0]                  gated_q, gated_d;
  logic [SUM_W-1:0]                  sum_q, sum_d;

  // Output register
  logic                              out_valid_q;
  logic [CNT_W-1:0]                  out_acc_q, out_miss_q, out_gated_q;
  logic [awstat_pkg::SPREAD_W-1:0]   out_raw_spread_q, out_filt_spread_q;
  logic [SUM_W-1:0]                  out_sum_q;

  logic                              in_fire;
  logic                              s1_fire;
  logic                              snap_fire;
  logic [awstat_pkg::ANGLE_W-1:0]    ref_base;
  logic [awstat_pkg::ANGLE_W-1:0]    raw_fixed;
  logic signed [DEV_W-1:0]           raw_dev, filt_dev;
  logic signed [DEV_W-1:0]           raw_low_base, raw_high_base;
  logic signed [DEV_W-1:0]           filt_low_base, filt_high_base;
  logic [SUM_W:0]                    sum_ext;
  logic signed [DEV_W:0]             raw_diff, filt_diff;
  logic [awstat_pkg::SPREAD_W-1:0]   raw_spread, filt_spread;

  // Handshake: stage 1 stalls only on a snapshot facing a full output register
  assign s1_fire    = s1_valid_q && ((s1_action_q != awstat_pkg::ACT_SNAPSHOT) ||
                                     !out_valid_q || out_ready_i);
  assign snap_fire  = s1_fire && (s1_action_q == awstat_pkg::ACT_SNAPSHOT);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Square the residual on the way in
  assign res_prod = residual_i * residual_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_i;
      s1_raw_q    <= raw_angle_i;
      s1_filt_q   <= filtered_angle_i;
      s1_gated_q  <= was_gated_i;
      s1_locked_q <= is_locked_i;
      s1_sq_q     <= res_prod[awstat_pkg::SQ_W-1:0];
    end
  end

  // Deviations against the reference; the first accounted sample is its own reference
  assign ref_base  = ref_valid_q ? ref_q : s1_filt_q;
  assign raw_fixed = {s1_raw_q, {awstat_pkg::FRACTION_BITS{1'b0}}};

  awstat_deviation u_raw_dev (
    .angle_i (raw_fixed),
    .ref_i   (ref_base),
    .dev_o   (raw_dev)
  );

  awstat_deviation u_filt_dev (
    .angle_i (s1_filt_q),
    .ref_i   (ref_base),
    .dev_o   (filt_dev)
  );

  assign raw_low_base   = ref_valid_q ? raw_low_q   : '0;
  assign raw_high_base  = ref_valid_q ? raw_high_q  : '0;
  assign filt_low_base  = ref_valid_q ? filt_low_q  : '0;
  assign filt_high_base = ref_valid_q ? filt_high_q : '0;

  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(s1_sq_q);

  // Window state update
  always_comb begin
    ref_valid_d = ref_valid_q;
    ref_d       = ref_q;
    raw_low_d   = raw_low_q;
    raw_high_d  = raw_high_q;
    filt_low_d  = filt_low_q;
    filt_high_d = filt_high_q;
    acc_d       = acc_q;
    miss_d      = miss_q;
    gated_d     = gated_q;
    sum_d       = sum_q;
    if (s1_fire) begin
      case (s1_action_q)
        awstat_pkg::ACT_SAMPLE: begin
          if (s1_gated_q) begin
            gated_d = (gated_q == '1) ? gated_q : gated_q + 1'b1;
          end else if (s1_locked_q) begin
            ref_valid_d = 1'b1;
            ref_d       = ref_base;
            raw_low_d   = (raw_dev < raw_low_base)    ? raw_dev  : raw_low_base;
            raw_high_d  = (raw_dev > raw_high_base)   ? raw_dev  : raw_high_base;
            filt_low_d  = (filt_dev < filt_low_base)  ? filt_dev : filt_low_base;
            filt_high_d = (filt_dev > filt_high_base) ? filt_dev : filt_high_base;
            sum_d       = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            acc_d       = (acc_q == '1) ? acc_q : acc_q + 1'b1;
          end
        end
        awstat_pkg::ACT_MISS: begin
          miss_d = (miss_q == '1) ? miss_q : miss_q + 1'b1;
        end
        awstat_pkg::ACT_SNAPSHOT: begin
          ref_valid_d = 1'b0;
          ref_d       = '0;
          raw_low_d   = '0;
          raw_high_d  = '0;
          filt_low_d  = '0;
          filt_high_d = '0;
          acc_d       = '0;
          miss_d      = '0;
          gated_d     = '0;
          sum_d       = '0;
        end
        default: begin
          // unused code: drop the transaction
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_valid_q <= 1'b0;
      ref_q       <= '0;
      raw_low_q   <= '0;
      raw_high_q  <= '0;
      filt_low_q  <= '0;
      filt_high_q <= '0;
      acc_q       <= '0;
      miss_q      <= '0;
      gated_q     <= '0;
      sum_q       <= '0;
    end else begin
      ref_valid_q <= ref_valid_d;
      ref_q       <= ref_d;
      raw_low_q   <= raw_low_d;
      raw_high_q  <= raw_high_d;
      filt_low_q  <= filt_low_d;
      filt_high_q <= filt_high_d;
      acc_q       <= acc_d;
      miss_q      <= miss_d;
      gated_q     <= gated_d;
      sum_q       <= sum_d;
    end
  end

  // Spreads: zero for an empty window, clamp a negative span to zero
  assign raw_diff  = {raw_high_q[DEV_W-1], raw_high_q} - {raw_low_q[DEV_W-1], raw_low_q};
  assign filt_diff = {filt_high_q[DEV_W-1], filt_high_q} - {filt_low_q[DEV_W-1], filt_low_q};
  assign raw_spread  = ((acc_q == '0) || raw_diff[DEV_W])  ? '0 :
                       raw_diff[awstat_pkg::SPREAD_W-1:0];
  assign filt_spread = ((acc_q == '0) || filt_diff[DEV_W]) ? '0 :
                       filt_diff[awstat_pkg::SPREAD_W-1:0];

  // Output register: load on snapshot, hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_fire) begin
      out_acc_q         <= acc_q;
      out_miss_q        <= miss_q;
      out_gated_q       <= gated_q;
      out_raw_spread_q  <= raw_spread;
      out_filt_spread_q <= filt_spread;
      out_sum_q         <= sum_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign sample_count_o        = out_acc_q;
  assign miss_count_o          = out_miss_q;
  assign gated_count_o         = out_gated_q;
  assign raw_spread_o          = out_raw_spread_q;
  assign filtered_spread_o     = out_filt_spread_q;
  assign residual_square_sum_o = out_sum_q;

`ifndef SYNTHESIS
  // The reference is latched exactly when the window holds an accounted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_valid_q == (acc_q != '0))
    else $error("reference valid out of step with sample count");

  // Without a reference the extremes stay cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ref_valid_q |-> (raw_low_q == '0 && raw_high_q == '0 &&
                      filt_low_q == '0 && filt_high_q == '0))
    else $error("extremes set without a reference");

  // A snapshot empties the window and fills the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_fire |=> (out_valid_q && acc_q == '0 && miss_q == '0 &&
                   gated_q == '0 && sum_q == '0))
    else $error("snapshot did not clear the window");

  // Input stalls only behind a snapshot waiting on a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_action_q == awstat_pkg::ACT_SNAPSHOT &&
                     out_valid_q && !out_ready_i))
    else $error("input stalled without cause");

  // An empty window reports zero spreads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_acc_q == '0) |->
      (out_raw_spread_q == '0 && out_filt_spread_q == '0))
    else $error("nonzero spread for an empty window");
`endif

endmodule

### hw/rtl/awstat_deviation.sv
module awstat_deviation (
  input  logic        [awstat_pkg::ANGLE_W-1:0] angle_i,
  input  logic        [awstat_pkg::ANGLE_W-1:0] ref_i,
  output logic signed [awstat_pkg::DEV_W-1:0]   dev_o
);

  logic [awstat_pkg::ANGLE_W-1:0]                       diff;
  logic [awstat_pkg::ANGLE_W-1:0]                       mag;
  logic [awstat_pkg::ANGLE_W-1:0]                       mag_rnd;
  logic [awstat_pkg::ANGLE_W-awstat_pkg::FRACTION_BITS-1:0] whole;
  logic [awstat_pkg::DEV_W-1:0]                         whole_ext;
  logic                                                 neg;

  // Wrap the difference to one turn; the top bit then marks the negative half
  assign diff = angle_i - ref_i;
  assign neg  = diff[awstat_pkg::ANGLE_W-1];

  // Round the magnitude to whole counts, ties away from zero
  assign mag       = neg ? (~diff + 1'b1) : diff;
  assign mag_rnd   = mag + awstat_pkg::ANGLE_W'(awstat_pkg::ROUND_HALF);
  assign whole     = mag_rnd[awstat_pkg::ANGLE_W-1:awstat_pkg::FRACTION_BITS];
  assign whole_ext = {1'b0, whole};

  // Restore the sign
  assign dev_o = neg ? (~whole_ext + 1'b1) : whole_ext;

endmodule

### sim/testbench.sv
module testbench;

  localparam int unsigned COUNTS_PER_TURN = awstat_pkg::COUNTS_PER_TURN;
  localparam int unsigned FRACTION_BITS   = awstat_pkg::FRACTION_BITS;
  localparam int unsigned RAW_W           = awstat_pkg::RAW_W;
  localparam int unsigned ANGLE_W         = awstat_pkg::ANGLE_W;
  localparam int unsigned SPREAD_W        = awstat_pkg::SPREAD_W;
  localparam int unsigned RES_W           = awstat_pkg::RES_W;
  localparam int unsigned CNT_W           = awstat_pkg::CNT_W;
  localparam int unsigned SUM_W           = awstat_pkg::SUM_W;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int PRINT_LIMIT = 40;
  localparam int SPREAD_TOP = (1 << SPREAD_W) - 1;
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic signed [RES_W-1:0] RES_MAX = ~RES_MIN;

  typedef struct {
    logic [CNT_W-1:0]    samples;
    logic [CNT_W-1:0]    misses;
    logic [CNT_W-1:0]    gated;
    logic [SPREAD_W-1:0] raw_spread;
    logic [SPREAD_W-1:0] filtered_spread;
    logic [SUM_W-1:0]    square_sum;
  } window_figures_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [1:0]                 action_i;
  logic [RAW_W-1:0]           raw_angle_i;
  logic [ANGLE_W-1:0]         filtered_angle_i;
  logic signed [RES_W-1:0]    residual_i;
  logic                       was_gated_i;
  logic                       is_locked_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [CNT_W-1:0]           sample_count_o;
  logic [CNT_W-1:0]           miss_count_o;
  logic [CNT_W-1:0]           gated_count_o;
  logic [SPREAD_W-1:0]        raw_spread_o;
  logic [SPREAD_W-1:0]        filtered_spread_o;
  logic [SUM_W-1:0]           residual_square_sum_o;

  // Predicted window state
  logic [ANGLE_W-1:0] win_reference;
  logic               win_has_reference;
  int                 raw_dev_lo;
  int                 raw_dev_hi;
  int                 filt_dev_lo;
  int                 filt_dev_hi;
  logic [CNT_W-1:0]   win_samples;
  logic [CNT_W-1:0]   win_misses;
  logic [CNT_W-1:0]   win_gated;
  logic [SUM_W-1:0]   win_square_sum;

  window_figures_t pending_snapshots[$];
  window_figures_t oldest_snapshot;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int item_total     = 0;
  int snapshot_total = 0;
  int quiet_cycles   = 0;

  angle_window_statistics u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .action_i              (action_i),
    .raw_angle_i           (raw_angle_i),
    .filtered_angle_i      (filtered_angle_i),
    .residual_i            (residual_i),
    .was_gated_i           (was_gated_i),
    .is_locked_i           (is_locked_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .sample_count_o        (sample_count_o),
    .miss_count_o          (miss_count_o),
    .gated_count_o         (gated_count_o),
    .raw_spread_o          (raw_spread_o),
    .filtered_spread_o     (filtered_spread_o),
    .residual_square_sum_o (residual_square_sum_o)
  );

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Saturating counter step
  function automatic logic [CNT_W-1:0] saturating_inc(input logic [CNT_W-1:0] value);
    return (&value) ? value : value + 1'b1;
  endfunction

  // Wrap the distance to the reference into half a turn, round ties away from zero
  function automatic int wrap_deviation(input longint angle_fixed);
    longint turn;
    longint half_lsb;
    longint d;
    turn     = longint'(COUNTS_PER_TURN) << FRACTION_BITS;
    half_lsb = (longint'(1) << FRACTION_BITS) >> 1;
    d = (angle_fixed - longint'(win_reference)) % turn;
    if (d < 0) d += turn;
    if (d >= turn / 2) d -= turn;
    if (d >= 0) return int'((d + half_lsb) >> FRACTION_BITS);
    return -int'((-d + half_lsb) >> FRACTION_BITS);
  endfunction

  // Peak-to-peak spread, zero for an empty window
  function automatic logic [SPREAD_W-1:0] spread_of(input int lo, input int hi);
    if (win_samples == '0 || hi < lo) return '0;
    if (hi - lo > SPREAD_TOP) return SPREAD_W'(SPREAD_TOP);
    return SPREAD_W'(hi - lo);
  endfunction

  task automatic clear_window();
    win_reference     = '0;
    win_has_reference = 1'b0;
    raw_dev_lo        = 0;
    raw_dev_hi        = 0;
    filt_dev_lo       = 0;
    filt_dev_hi       = 0;
    win_samples       = '0;
    win_misses        = '0;
    win_gated         = '0;
    win_square_sum    = '0;
  endtask

  // Advance the predicted window by one accepted transaction
  task automatic predict_window(input logic [1:0] act, input logic [RAW_W-1:0] raw,
                                input logic [ANGLE_W-1:0] filt,
                                input logic signed [RES_W-1:0] res,
                                input logic gated, input logic locked);
    int              dev;
    logic [SUM_W-1:0] square;
    window_figures_t fig;
    case (act)
      awstat_pkg::ACT_SAMPLE: begin
        if (gated) begin
          win_gated = saturating_inc(win_gated);
        end else if (locked) begin
          // latch the reference on the first accounted sample
          if (!win_has_reference) begin
            win_reference     = filt;
            win_has_reference = 1'b1;
            raw_dev_lo  = 0;
            raw_dev_hi  = 0;
            filt_dev_lo = 0;
            filt_dev_hi = 0;
          end
          dev = wrap_deviation(longint'(raw) << FRACTION_BITS);
          if (dev < raw_dev_lo) raw_dev_lo = dev;
          if (dev > raw_dev_hi) raw_dev_hi = dev;
          dev = wrap_deviation(longint'(filt));
          if (dev < filt_dev_lo) filt_dev_lo = dev;
          if (dev > filt_dev_hi) filt_dev_hi = dev;
          square = SUM_W'(longint'(res) * longint'(res));
          win_square_sum = (win_square_sum > ~square) ? '1 : win_square_sum + square;
          win_samples = saturating_inc(win_samples);
        end
      end
      awstat_pkg::ACT_MISS: begin
        win_misses = saturating_inc(win_misses);
      end
      awstat_pkg::ACT_SNAPSHOT: begin
        fig.samples         = win_samples;
        fig.misses          = win_misses;
        fig.gated           = win_gated;
        fig.raw_spread      = spread_of(raw_dev_lo, raw_dev_hi);
        fig.filtered_spread = spread_of(filt_dev_lo, filt_dev_hi);
        fig.square_sum      = win_square_sum;
        pending_snapshots.push_back(fig);
        clear_window();
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                 input logic [SUM_W-1:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH %s: got %0h, want %0h (snapshot %0d)", what, got, want,
               snapshot_total);
    mismatch_count++;
  endtask

  // Send one input transaction, idling first at the current rate
  task automatic send_item(input logic [1:0] act, input logic [RAW_W-1:0] raw,
                           input logic [ANGLE_W-1:0] filt,
                           input logic signed [RES_W-1:0] res,
                           input logic gated, input logic locked);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    raw_angle_i      <= raw;
    filtered_angle_i <= filt;
    residual_i       <= res;
    was_gated_i      <= gated;
    is_locked_i      <= locked;
    do @(posedge clk_i); while (!in_ready_o);
    item_total++;
    predict_window(act, raw, filt, res, gated, locked);
  endtask

  // Send an action with random junk in every other field
  task automatic send_junk(input logic [1:0] act);
    send_item(act, RAW_W'($urandom), ANGLE_W'($urandom), RES_W'($urandom),
              1'($urandom), 1'($urandom));
  endtask

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each snapshot against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_snapshots.size() == 0) begin
        report_mismatch("unexpected snapshot", sample_count_o, '0);
      end else begin
        oldest_snapshot = pending_snapshots.pop_front();
        if (sample_count_o !== oldest_snapshot.samples)
          report_mismatch("sample_count", sample_count_o, oldest_snapshot.samples);
        if (miss_count_o !== oldest_snapshot.misses)
          report_mismatch("miss_count", miss_count_o, oldest_snapshot.misses);
        if (gated_count_o !== oldest_snapshot.gated)
          report_mismatch("gated_count", gated_count_o, oldest_snapshot.gated);
        if (raw_spread_o !== oldest_snapshot.raw_spread)
          report_mismatch("raw_spread", raw_spread_o, oldest_snapshot.raw_spread);
        if (filtered_spread_o !== oldest_snapshot.filtered_spread)
          report_mismatch("filtered_spread", filtered_spread_o,
                          oldest_snapshot.filtered_spread);
        if (residual_square_sum_o !== oldest_snapshot.square_sum)
          report_mismatch("residual_square_sum", residual_square_sum_o,
                          oldest_snapshot.square_sum);
      end
      snapshot_total++;
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  function automatic int window_jitter();
    case ($urandom_range(3))
      0:       return 255;
      1:       return 4095;
      2:       return 1 << 18;
      default: return 1 << (ANGLE_W - 1);
    endcase
  endfunction

  // Snapshot an empty window twice in a row, with junk in the unused fields
  task automatic test_empty_snapshot();
    send_junk(awstat_pkg::ACT_SNAPSHOT);
    send_item(awstat_pkg::ACT_SNAPSHOT, '1, '1, RES_MIN, 1'b1, 1'b1);
  endtask

  // Count misses and gated samples, drop unlocked samples and the unused code
  task automatic test_counters_and_ignored();
    send_junk(awstat_pkg::ACT_MISS);
    send_item(awstat_pkg::ACT_MISS, '1, '1, RES_MAX, 1'b0, 1'b0);
    send_item(awstat_pkg::ACT_SAMPLE, 14'd100, 22'd5000, RES_MAX, 1'b1, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, 14'd200, 22'd9000, RES_MIN, 1'b1, 1'b0);
    send_item(awstat_pkg::ACT_SAMPLE, 14'd300, 22'd1234, RES_MAX, 1'b0, 1'b0);
    send_item(ACT_UNUSED, '1, '1, RES_MIN, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SNAPSHOT, '0, '0, '0, 1'b0, 1'b0);
  endtask

  // Hit the half-turn wrap, the angle extremes and rounding ties from reference zero
  task automatic test_wrap_and_rounding();
    send_item(awstat_pkg::ACT_SAMPLE, '0, '0, RES_MIN, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, '1, '1, RES_MAX, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, 14'h2000, 22'h200000, '0, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, 14'h1FFF, 22'h1FFFFF, 14'sd1, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, '0, 22'h000080, -14'sd1, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, '0, 22'h3FFF80, '0, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, '0, 22'h00007F, '0, 1'b0, 1'b1);
    send_junk(awstat_pkg::ACT_SNAPSHOT);
  endtask

  // Rebase on a reference with a half-count fraction and wrap across zero
  task automatic test_rebased_window();
    send_item(awstat_pkg::ACT_SAMPLE, 14'h2ABC, 22'h2ABC80, 14'sd77, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, '0, 22'h0ABC80, -14'sd300, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_SAMPLE, '1, 22'h2ABD00, '0, 1'b0, 1'b1);
    send_item(awstat_pkg::ACT_MISS, '0, '0, '0, 1'b0, 1'b0);
    send_item(awstat_pkg::ACT_SNAPSHOT, '0, '0, '0, 1'b0, 1'b0);
  endtask

  // Random windows: mostly locked samples clustered around a base angle
  task automatic run_random_windows(input int goal);
    int                      done;
    int                      pick;
    int                      jitter;
    logic [ANGLE_W-1:0]      base;
    logic [ANGLE_W-1:0]      filt;
    logic [RAW_W-1:0]        raw;
    logic signed [RES_W-1:0] res;
    logic                    gated;
    done   = 0;
    base   = ANGLE_W'($urandom);
    jitter = window_jitter();
    while (done < goal) begin
      pick = $urandom_range(99);
      filt = base + ANGLE_W'($urandom_range(2 * jitter)) - ANGLE_W'(jitter);
      if ($urandom_range(9) == 0) raw = RAW_W'($urandom);
      else raw = RAW_W'(filt >> FRACTION_BITS) + RAW_W'($urandom_range(8)) - RAW_W'(4);
      if ($urandom_range(9) == 0) res = RES_W'($urandom);
      else res = RES_W'($urandom_range(200)) - RES_W'(100);
      if (pick < 68) begin
        send_item(awstat_pkg::ACT_SAMPLE, raw, filt, res, $urandom_range(11) == 0, 1'b1);
        done++;
      end else if (pick < 78) begin
        send_junk(awstat_pkg::ACT_MISS);
        done++;
      end else if (pick < 84) begin
        gated = 1'($urandom);
        send_item(awstat_pkg::ACT_SAMPLE, raw, filt, res, gated, 1'b0);
        if (gated) done++;
      end else if (pick < 89) begin
        send_junk(ACT_UNUSED);
      end else begin
        send_junk(awstat_pkg::ACT_SNAPSHOT);
        done++;
        base   = ANGLE_W'($urandom);
        jitter = window_jitter();
      end
    end
  endtask

  task automatic test_no_idling();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_windows(110);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 54;
    recv_stall_pct = 0;
    run_random_windows(105);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    run_random_windows(105);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    run_random_windows(105);
  endtask

  // Reset, run every test in turn, then drain and judge
  initial begin
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    action_i         <= awstat_pkg::ACT_SAMPLE;
    raw_angle_i      <= '0;
    filtered_angle_i <= '0;
    residual_i       <= '0;
    was_gated_i      <= 1'b0;
    is_locked_i      <= 1'b0;
    out_ready_i      <= 1'b0;
    clear_window();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_snapshot();
    test_counters_and_ignored();
    test_wrap_and_rounding();
    test_rebased_window();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();

    in_valid_i <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d input transactions and %0d snapshots, including corner angles,",
             item_total, snapshot_total);
    $display("rounding ties, ignored codes and four idle/stall mixes; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
